FILE: rtl/uer_pkg.sv
package uer_pkg;

    // Echo time per centimeter, in timer ticks
    localparam int unsigned TICKS_PER_CM = 58;

    // Width of a clamped tick total handed to the divider
    localparam int unsigned TICK_BITS = 22;

    // Tick total at and above which the distance saturates
    localparam int unsigned SAT_TICKS = TICKS_PER_CM * 65536;

    // Reciprocal of 58 for tick totals below SAT_TICKS
    localparam int unsigned RECIP_SHIFT = 30;
    localparam int unsigned RECIP_BITS  = 25;
    localparam logic [RECIP_BITS-1:0] RECIP_MUL =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + TICKS_PER_CM - 1) / TICKS_PER_CM);

    localparam int unsigned DIST_BITS = 16;

    // Event codes carried in the mode field
    localparam logic [2:0] MODE_START   = 3'd0;
    localparam logic [2:0] MODE_CAPTURE = 3'd1;
    localparam logic [2:0] MODE_WRAP    = 3'd2;
    localparam logic [2:0] MODE_CHECK   = 3'd3;
    localparam logic [2:0] MODE_RELEASE = 3'd4;

    // Reported phase codes
    localparam logic [1:0] PCODE_IDLE = 2'd0;
    localparam logic [1:0] PCODE_RISE = 2'd1;
    localparam logic [1:0] PCODE_FALL = 2'd2;
    localparam logic [1:0] PCODE_DONE = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_RISE = 4'b0010,
        PH_FALL = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    // Item state between the event stage and the distance stage
    typedef struct packed {
        logic                 trig;
        logic                 falling;
        logic                 fresh;
        logic [1:0]           phase_code;
        logic                 done;
        logic                 capture;
        logic                 sat;
        logic [TICK_BITS-1:0] ticks;
    } stage_t;

    function automatic logic [1:0] phase_code_of(input phase_t ph);
        logic [1:0] code;
        unique case (ph)
            PH_IDLE: code = PCODE_IDLE;
            PH_RISE: code = PCODE_RISE;
            PH_FALL: code = PCODE_FALL;
            PH_DONE: code = PCODE_DONE;
            default: code = PCODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/uer_tick_div.sv
module uer_tick_div (
    input  logic [uer_pkg::TICK_BITS-1:0] ticks,
    output logic [uer_pkg::DIST_BITS-1:0] quotient
);
    import uer_pkg::*;

    localparam int unsigned PROD_BITS = TICK_BITS + RECIP_BITS;

    logic [PROD_BITS-1:0] product;

    // Divide by 58 through the reciprocal; exact for totals below SAT_TICKS
    assign product  = PROD_BITS'(ticks) * PROD_BITS'(RECIP_MUL);
    assign quotient = product[RECIP_SHIFT +: DIST_BITS];

endmodule

FILE: rtl/ultrasonic_echo_ranger.sv
// Event-driven echo ranger: each input item is one event (start, capture edge,
// timer wrap, check, release) and yields exactly one result item. One item is
// accepted per clock while the input is not stalled; an accepted item waits in
// the event stage, then passes the distance stage into the output register, and
// the input stalls only while both stages hold items and the output is not taken.
// The distance (t2 - t1 + wraps * (timer_top + 1)) / 58 is split so that the
// wrap product is kept registered ahead of time, the event stage forms and
// clamps the tick total, and the distance stage divides by 58 with a
// reciprocal multiply. timer_top is written through the cfg channel, which
// is always ready; write it only while no item is in flight.
module ultrasonic_echo_ranger #(
    parameter int STAMP_BITS = 16,
    parameter int WRAP_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [15:0] capture_stamp,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        trigger_pulse,
    output logic        edge_falling,
    output logic [15:0] distance_cm,
    output logic        fresh,
    output logic [1:0]  phase_now,
    output logic        reading_done,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import uer_pkg::*;

    localparam int PROD_BITS  = WRAP_BITS + 17;
    localparam int TOTAL_BITS = ((STAMP_BITS > PROD_BITS) ? STAMP_BITS : PROD_BITS) + 2;

    // Control state
    phase_t                 phase_reg, phase_next;
    logic [STAMP_BITS-1:0]  first_stamp_reg, first_stamp_next;
    logic [WRAP_BITS-1:0]   wrap_count_reg, wrap_count_next;
    logic                   falling_reg, falling_next;
    logic                   done_reg, done_next;
    logic [15:0]            timer_top_reg, timer_top_next;
    logic [PROD_BITS-1:0]   wrap_ticks_reg, wrap_ticks_next;
    logic [15:0]            last_distance_reg, last_distance_next;

    // Pipeline registers
    logic                   s1_valid_reg, s1_valid_next;
    stage_t                 s1_reg, s1_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   trig_out_reg;
    logic                   falling_out_reg;
    logic [15:0]            dist_out_reg;
    logic                   fresh_out_reg;
    logic [1:0]             phase_out_reg;
    logic                   done_out_reg;

    logic                   in_fire;
    logic                   out_load;
    logic [STAMP_BITS-1:0]  stamp;
    logic [16:0]            period;
    logic [TOTAL_BITS-1:0]  total;
    logic                   total_neg;
    logic                   total_sat;
    logic [15:0]            quotient;
    logic [15:0]            dist_new;

    // Handshake and stage flow
    assign out_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || out_load;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign s1_valid_next  = in_fire ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    assign stamp = STAMP_BITS'(capture_stamp);

    // Tick total for a falling capture, from the prepared wrap product
    assign total = TOTAL_BITS'(stamp) - TOTAL_BITS'(first_stamp_reg)
                 + TOTAL_BITS'(wrap_ticks_reg);
    assign total_neg = total[TOTAL_BITS-1];
    assign total_sat = !total_neg && (total >= TOTAL_BITS'(SAT_TICKS));

    // Advance the event sequence for an accepted item
    always_comb
    begin
        phase_next       = phase_reg;
        first_stamp_next = first_stamp_reg;
        wrap_count_next  = wrap_count_reg;
        falling_next     = falling_reg;
        done_next        = done_reg;
        s1_next          = s1_reg;
        if (in_fire)
        begin
            s1_next.trig    = 1'b0;
            s1_next.fresh   = 1'b0;
            s1_next.capture = 1'b0;
            unique case (mode)
                MODE_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        falling_next = 1'b0;
                        done_next    = 1'b0;
                        phase_next   = PH_RISE;
                        s1_next.trig = 1'b1;
                    end
                end
                MODE_CAPTURE:
                begin
                    if (phase_reg == PH_RISE)
                    begin
                        first_stamp_next = stamp;
                        wrap_count_next  = '0;
                        falling_next     = 1'b1;
                        phase_next       = PH_FALL;
                    end
                    else if (phase_reg == PH_FALL)
                    begin
                        wrap_count_next = '0;
                        done_next       = 1'b1;
                        phase_next      = PH_DONE;
                        s1_next.capture = 1'b1;
                    end
                end
                MODE_WRAP:
                begin
                    wrap_count_next = wrap_count_reg + 1'b1;
                end
                MODE_CHECK:
                begin
                    if (phase_reg == PH_DONE)
                    begin
                        s1_next.fresh = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                end
                MODE_RELEASE:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                end
            endcase
            s1_next.falling    = falling_next;
            s1_next.done       = done_next;
            s1_next.phase_code = phase_code_of(phase_next);
            s1_next.sat        = total_sat;
            s1_next.ticks      = total_neg ? '0 : total[TICK_BITS-1:0];
        end
    end

    // Keep wraps * (timer_top + 1) registered for the next capture
    assign timer_top_next  = cfg_valid ? cfg_data : timer_top_reg;
    assign period          = {1'b0, timer_top_next} + 17'd1;
    assign wrap_ticks_next = PROD_BITS'(wrap_count_next) * PROD_BITS'(period);

    // Distance stage
    uer_tick_div u_div (
        .ticks    (s1_reg.ticks),
        .quotient (quotient)
    );

    assign dist_new = s1_reg.sat ? 16'hFFFF : quotient;
    assign last_distance_next = (out_load && s1_reg.capture) ? dist_new : last_distance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            first_stamp_reg   <= '0;
            wrap_count_reg    <= '0;
            falling_reg       <= 1'b0;
            done_reg          <= 1'b0;
            timer_top_reg     <= 16'hFFFF;
            wrap_ticks_reg    <= '0;
            last_distance_reg <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            first_stamp_reg   <= first_stamp_next;
            wrap_count_reg    <= wrap_count_next;
            falling_reg       <= falling_next;
            done_reg          <= done_next;
            timer_top_reg     <= timer_top_next;
            wrap_ticks_reg    <= wrap_ticks_next;
            last_distance_reg <= last_distance_next;
            s1_valid_reg      <= s1_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Hold payloads; load them as items advance
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        if (out_load)
        begin
            trig_out_reg    <= s1_reg.trig;
            falling_out_reg <= s1_reg.falling;
            dist_out_reg    <= last_distance_next;
            fresh_out_reg   <= s1_reg.fresh;
            phase_out_reg   <= s1_reg.phase_code;
            done_out_reg    <= s1_reg.done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_pulse = trig_out_reg;
    assign edge_falling  = falling_out_reg;
    assign distance_cm   = dist_out_reg;
    assign fresh         = fresh_out_reg;
    assign phase_now     = phase_out_reg;
    assign reading_done  = done_out_reg;

    // A start result always leaves the sequence waiting for the rising edge
    a_trig_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trigger_pulse |-> phase_now == PCODE_RISE && !edge_falling)
        else $error("start result with wrong phase");

    // A fresh reading returns to idle with a completed measurement
    a_fresh_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fresh |-> phase_now == PCODE_IDLE && reading_done)
        else $error("fresh reading without completed measurement");

    // Rising-edge selection excludes the later phases
    a_edge_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !edge_falling |-> phase_now != PCODE_FALL && phase_now != PCODE_DONE
            && !reading_done)
        else $error("rising capture selected in a late phase");

    // A stalled output keeps the event stage full and unchanged
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |=> s1_valid_reg && $stable(s1_reg))
        else $error("event stage moved during output stall");

endmodule
